[design/zmt_pkg.sv]
// shared types and constants for the zone mass transfer block
`default_nettype none

package zmt_pkg;

	// default sizing handed to the top level parameters
	localparam int MAX_ZONES_DEF     = 16;
	localparam int FRACTION_BITS_DEF = 16;

	// fixed field widths
	localparam int MASS_W    = 48;
	localparam int ZONE_W    = 6;
	localparam int ACTION_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int ZCFG_W    = 7;

	// mass operand is split in two halves for the shared multiplier
	localparam int SPLIT = 24;

	localparam logic [MASS_W-1:0] MASS_MAX = {MASS_W{1'b1}};

	// input actions
	localparam logic [ACTION_W-1:0] ACT_LOAD_FRAC = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOAD_MASS = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RUN       = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ZONES      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAS_SEL    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAS_FLOOR  = 2'd2;

	// reset values of the configuration registers
	localparam logic [ZCFG_W-1:0] ZONES_RST     = 7'd16;
	localparam logic              GAS_SEL_RST   = 1'b1;
	localparam logic [MASS_W-1:0] GAS_FLOOR_RST = 48'd1;

	// sequencer states
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_INIT_RD,
		S_INIT_WR,
		S_EL_RD,
		S_MUL_LO,
		S_MUL_HI,
		S_COMB,
		S_EL_WR,
		S_ROW_RD,
		S_ROW_WR,
		S_FIN_RD,
		S_FIN_WR
	} state_t;

	// steps of the shared scaling unit
	typedef struct packed {
		logic mul_lo;
		logic mul_hi;
		logic combine;
	} scale_ctl_t;

endpackage

`default_nettype wire

[design/zone_mass_transfer_step.sv]
// Zone mass exchange through a transfer matrix, top level with sequencer.
// Loads are written directly and leave the block idle; a run walks every matrix
// element in five steps on the shared multiplier.
// Results come one per zone during the final pass; no stall needed.
// After reset the block is busy clearing the fraction and mass memories;
// configuration writes are taken at any time.
`default_nettype none

module zone_mass_transfer_step #(
	parameter int MAX_ZONES     = zmt_pkg::MAX_ZONES_DEF,
	parameter int FRACTION_BITS = zmt_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// command side
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [zmt_pkg::ACTION_W-1:0]     action,
	input  wire logic [zmt_pkg::ZONE_W-1:0]       source_zone,
	input  wire logic [zmt_pkg::ZONE_W-1:0]       target_zone,
	input  wire logic [zmt_pkg::MASS_W-1:0]       value,
	// result side
	output logic                                  result_valid,
	output logic      [zmt_pkg::ZONE_W-1:0]       zone,
	output logic      [zmt_pkg::MASS_W-1:0]       new_mass,
	output logic                                  last,
	output logic                                  row_overflow,
	// configuration write channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [zmt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [zmt_pkg::MASS_W-1:0]       cfg_data
);

	localparam int ZW    = $clog2(MAX_ZONES);
	localparam int FW    = FRACTION_BITS + 1;
	localparam int FDEP  = MAX_ZONES * MAX_ZONES;
	localparam int FAW   = $clog2(FDEP);
	localparam int NW    = $clog2(MAX_ZONES + 1);
	localparam int ACC_W = zmt_pkg::MASS_W + ZW + 2;
	localparam int RSW   = FW + ZW;
	localparam int MW    = zmt_pkg::MASS_W;

	zmt_pkg::state_t state_q, state_d;

	// configuration registers
	logic [zmt_pkg::ZCFG_W-1:0] zones_q;
	logic                       gas_sel_q;
	logic [MW-1:0]              gas_floor_q;

	// sequencer registers
	logic [ZW-1:0]    i_q;
	logic [ZW-1:0]    j_q;
	logic [NW-1:0]    n_q;
	logic [FAW-1:0]   fa_q;
	logic [FAW-1:0]   row_base_q;
	logic [FAW-1:0]   clr_q;
	logic [ACC_W-1:0] out_sum_q;
	logic [RSW-1:0]   row_sum_q;
	logic             ovf_q;

	// result registers
	logic             res_valid_q;
	logic [zmt_pkg::ZONE_W-1:0] res_zone_q;
	logic [MW-1:0]    res_mass_q;
	logic             res_last_q;
	logic             res_ovf_q;

	// memory ports
	logic             frac_we;
	logic [FAW-1:0]   frac_waddr;
	logic [FW-1:0]    frac_wdata;
	logic [FW-1:0]    frac_rdata;
	logic             mass_we;
	logic [ZW-1:0]    mass_waddr;
	logic [MW-1:0]    mass_wdata;
	logic [MW-1:0]    mass_rdata;
	logic             acc_we;
	logic [ZW-1:0]    acc_waddr;
	logic [ACC_W-1:0] acc_wdata;
	logic [ZW-1:0]    acc_raddr;
	logic [ACC_W-1:0] acc_rdata;

	// misc
	logic                accept;
	logic                src_ok;
	logic                dst_ok;
	logic [NW-1:0]       n_eff;
	logic [NW-1:0]       n_last;
	logic                i_last;
	logic                j_last;
	logic [FAW-1:0]      load_addr;
	logic [FW-1:0]       load_frac;
	logic [MW-1:0]       part;
	logic [ACC_W-1:0]    floor_ext;
	logic [MW-1:0]       clamped;
	zmt_pkg::scale_ctl_t sctl;

	assign busy      = (state_q != zmt_pkg::S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// load decode
	assign src_ok    = ({1'b0, source_zone} < 7'(MAX_ZONES));
	assign dst_ok    = ({1'b0, target_zone} < 7'(MAX_ZONES));
	assign load_addr = FAW'(FAW'(source_zone[ZW-1:0]) * FAW'(MAX_ZONES))
	                 + FAW'(target_zone[ZW-1:0]);
	always_comb begin
		if (source_zone == target_zone) begin
			load_frac = '0;
		end else if (value > (MW'(1) << FRACTION_BITS)) begin
			load_frac = FW'(1) << FRACTION_BITS;
		end else begin
			load_frac = value[FW-1:0];
		end
	end

	// zone count, saturated to the array size
	assign n_eff  = (zones_q > 7'(MAX_ZONES)) ? NW'(MAX_ZONES) : NW'(zones_q);
	assign n_last = n_q - NW'(1);
	assign i_last = (NW'(i_q) == n_last);
	assign j_last = (NW'(j_q) == n_last);

	// fraction memory write: clearing pass or load
	always_comb begin
		if (state_q == zmt_pkg::S_CLEAR) begin
			frac_we    = 1'b1;
			frac_waddr = clr_q;
			frac_wdata = '0;
		end else begin
			frac_we    = accept && (action == zmt_pkg::ACT_LOAD_FRAC) && src_ok && dst_ok;
			frac_waddr = load_addr;
			frac_wdata = load_frac;
		end
	end

	// clamp the final sum to floor and maximum
	assign floor_ext = gas_sel_q ? ACC_W'(gas_floor_q) : '0;
	always_comb begin
		if ($signed(acc_rdata) < $signed(floor_ext)) begin
			clamped = gas_sel_q ? gas_floor_q : '0;
		end else if ($signed(acc_rdata) > $signed(ACC_W'(zmt_pkg::MASS_MAX))) begin
			clamped = zmt_pkg::MASS_MAX;
		end else begin
			clamped = acc_rdata[MW-1:0];
		end
	end

	// mass memory write: clearing pass, load or final pass
	always_comb begin
		mass_we    = 1'b0;
		mass_waddr = source_zone[ZW-1:0];
		mass_wdata = value;
		case (state_q)
			zmt_pkg::S_CLEAR: begin
				mass_we    = (clr_q < FAW'(MAX_ZONES));
				mass_waddr = clr_q[ZW-1:0];
				mass_wdata = '0;
			end
			zmt_pkg::S_FIN_WR: begin
				mass_we    = 1'b1;
				mass_waddr = i_q;
				mass_wdata = clamped;
			end
			zmt_pkg::S_IDLE: begin
				mass_we = accept && (action == zmt_pkg::ACT_LOAD_MASS) && src_ok;
			end
			default: begin
				mass_we = 1'b0;
			end
		endcase
	end

	// accumulator ports
	always_comb begin
		acc_we    = 1'b0;
		acc_waddr = i_q;
		acc_wdata = ACC_W'(mass_rdata);
		case (state_q)
			zmt_pkg::S_INIT_WR: begin
				acc_we = 1'b1;
			end
			zmt_pkg::S_EL_WR: begin
				acc_we    = 1'b1;
				acc_waddr = j_q;
				acc_wdata = acc_rdata + ACC_W'(part);
			end
			zmt_pkg::S_ROW_WR: begin
				acc_we    = 1'b1;
				acc_wdata = acc_rdata - out_sum_q;
			end
			default: begin
				acc_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (state_q inside {zmt_pkg::S_EL_RD, zmt_pkg::S_MUL_LO, zmt_pkg::S_MUL_HI,
		                    zmt_pkg::S_COMB, zmt_pkg::S_EL_WR}) begin
			acc_raddr = j_q;
		end else begin
			acc_raddr = i_q;
		end
	end

	// scaling unit steps
	assign sctl.mul_lo  = (state_q == zmt_pkg::S_MUL_LO);
	assign sctl.mul_hi  = (state_q == zmt_pkg::S_MUL_HI);
	assign sctl.combine = (state_q == zmt_pkg::S_COMB);

	zmt_ram #(.WIDTH(FW), .DEPTH(FDEP)) u_frac_ram (
		.clk   (clk),
		.we    (frac_we),
		.waddr (frac_waddr),
		.wdata (frac_wdata),
		.raddr (fa_q),
		.rdata (frac_rdata)
	);

	zmt_ram #(.WIDTH(MW), .DEPTH(MAX_ZONES)) u_mass_ram (
		.clk   (clk),
		.we    (mass_we),
		.waddr (mass_waddr),
		.wdata (mass_wdata),
		.raddr (i_q),
		.rdata (mass_rdata)
	);

	zmt_ram #(.WIDTH(ACC_W), .DEPTH(MAX_ZONES)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	zmt_scale_unit #(.FRACTION_BITS(FRACTION_BITS)) u_scale (
		.clk  (clk),
		.ctl  (sctl),
		.frac (frac_rdata),
		.mass (mass_rdata),
		.part (part)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			zmt_pkg::S_CLEAR: begin
				if (clr_q == FAW'(FDEP - 1)) begin
					state_d = zmt_pkg::S_IDLE;
				end
			end
			zmt_pkg::S_IDLE: begin
				if (accept && (action == zmt_pkg::ACT_RUN) && (n_eff != '0)) begin
					state_d = zmt_pkg::S_INIT_RD;
				end
			end
			zmt_pkg::S_INIT_RD: state_d = zmt_pkg::S_INIT_WR;
			zmt_pkg::S_INIT_WR: begin
				state_d = i_last ? zmt_pkg::S_EL_RD : zmt_pkg::S_INIT_RD;
			end
			zmt_pkg::S_EL_RD:  state_d = zmt_pkg::S_MUL_LO;
			zmt_pkg::S_MUL_LO: state_d = zmt_pkg::S_MUL_HI;
			zmt_pkg::S_MUL_HI: state_d = zmt_pkg::S_COMB;
			zmt_pkg::S_COMB:   state_d = zmt_pkg::S_EL_WR;
			zmt_pkg::S_EL_WR: begin
				state_d = j_last ? zmt_pkg::S_ROW_RD : zmt_pkg::S_EL_RD;
			end
			zmt_pkg::S_ROW_RD: state_d = zmt_pkg::S_ROW_WR;
			zmt_pkg::S_ROW_WR: begin
				state_d = i_last ? zmt_pkg::S_FIN_RD : zmt_pkg::S_EL_RD;
			end
			zmt_pkg::S_FIN_RD: state_d = zmt_pkg::S_FIN_WR;
			zmt_pkg::S_FIN_WR: begin
				state_d = i_last ? zmt_pkg::S_IDLE : zmt_pkg::S_FIN_RD;
			end
			default: state_d = zmt_pkg::S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= zmt_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zones_q     <= zmt_pkg::ZONES_RST;
			gas_sel_q   <= zmt_pkg::GAS_SEL_RST;
			gas_floor_q <= zmt_pkg::GAS_FLOOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				zmt_pkg::REG_ZONES:     zones_q     <= cfg_data[zmt_pkg::ZCFG_W-1:0];
				zmt_pkg::REG_GAS_SEL:   gas_sel_q   <= cfg_data[0];
				zmt_pkg::REG_GAS_FLOOR: gas_floor_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer counters and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			fa_q        <= '0;
			row_base_q  <= '0;
			out_sum_q   <= '0;
			row_sum_q   <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				zmt_pkg::S_CLEAR: begin
					clr_q <= clr_q + FAW'(1);
				end
				zmt_pkg::S_IDLE: begin
					i_q        <= '0;
					j_q        <= '0;
					fa_q       <= '0;
					row_base_q <= '0;
					out_sum_q  <= '0;
					row_sum_q  <= '0;
					ovf_q      <= 1'b0;
					n_q        <= n_eff;
				end
				zmt_pkg::S_INIT_WR: begin
					i_q <= i_last ? '0 : i_q + ZW'(1);
				end
				zmt_pkg::S_EL_WR: begin
					out_sum_q <= out_sum_q + ACC_W'(part);
					row_sum_q <= row_sum_q + RSW'(frac_rdata);
					if (!j_last) begin
						j_q  <= j_q + ZW'(1);
						fa_q <= fa_q + FAW'(1);
					end
				end
				zmt_pkg::S_ROW_WR: begin
					if (row_sum_q > (RSW'(1) << FRACTION_BITS)) begin
						ovf_q <= 1'b1;
					end
					out_sum_q  <= '0;
					row_sum_q  <= '0;
					j_q        <= '0;
					row_base_q <= row_base_q + FAW'(MAX_ZONES);
					fa_q       <= row_base_q + FAW'(MAX_ZONES);
					i_q        <= i_last ? '0 : i_q + ZW'(1);
				end
				zmt_pkg::S_FIN_WR: begin
					res_valid_q <= 1'b1;
					i_q         <= i_q + ZW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == zmt_pkg::S_FIN_WR) begin
			res_zone_q <= zmt_pkg::ZONE_W'(i_q);
			res_mass_q <= clamped;
			res_last_q <= i_last;
			res_ovf_q  <= ovf_q;
		end
	end

	assign result_valid = res_valid_q;
	assign zone         = res_zone_q;
	assign new_mass     = res_mass_q;
	assign last         = res_last_q;
	assign row_overflow = res_ovf_q;

endmodule

`default_nettype wire

[design/zmt_ram.sv]
// generic simple dual port ram with registered read
`default_nettype none

module zmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[design/zmt_scale_unit.sv]
// shared multiplier: floor(fraction * mass / 2^FRACTION_BITS) in two partial products
`default_nettype none

module zmt_scale_unit #(
	parameter int FRACTION_BITS = zmt_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire zmt_pkg::scale_ctl_t         ctl,
	input  wire logic [FRACTION_BITS:0]      frac,
	input  wire logic [zmt_pkg::MASS_W-1:0]  mass,
	output logic      [zmt_pkg::MASS_W-1:0]  part
);

	localparam int FW = FRACTION_BITS + 1;
	localparam int PW = FW + zmt_pkg::SPLIT;
	localparam int SW = PW + zmt_pkg::SPLIT;

	logic [zmt_pkg::SPLIT-1:0]  operand;
	logic [PW-1:0]              prod;
	logic [PW-1:0]              plo_q;
	logic [PW-1:0]              phi_q;
	logic [SW-1:0]              sum_wide;
	logic [zmt_pkg::MASS_W-1:0] part_q;

	// one multiplier, operand half chosen by step
	assign operand = ctl.mul_hi ? mass[zmt_pkg::MASS_W-1:zmt_pkg::SPLIT]
	                            : mass[zmt_pkg::SPLIT-1:0];
	assign prod = PW'(frac) * PW'(operand);

	// recombine the halves, exact since fraction is at most one
	assign sum_wide = (SW'(phi_q) << (zmt_pkg::SPLIT - FRACTION_BITS))
	                + (SW'(plo_q) >> FRACTION_BITS);

	always_ff @(posedge clk) begin
		if (ctl.mul_lo) begin
			plo_q <= prod;
		end
		if (ctl.mul_hi) begin
			phi_q <= prod;
		end
		if (ctl.combine) begin
			part_q <= sum_wide[zmt_pkg::MASS_W-1:0];
		end
	end

	assign part = part_q;

endmodule

`default_nettype wire

[design/zmt_port_check.sv]
// port level checks of the zone mass transfer block, bound to the top level
`default_nettype none

module zmt_port_check (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic [zmt_pkg::ACTION_W-1:0] action,
	input wire logic                         result_valid,
	input wire logic [zmt_pkg::ZONE_W-1:0]   zone,
	input wire logic                         last,
	input wire logic                         row_overflow
);

	// loads and unknown actions leave the block free in the next cycle
	a_load_single: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action != zmt_pkg::ACT_RUN)) |=> !busy)
		else $error("block busy after a load beat");

	// the final result of a run leaves the block free
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |-> !busy)
		else $error("block busy with the last result shown");

	// a result that is not the last keeps the block busy
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |-> busy)
		else $error("block free in the middle of a run");

	// the next result carries the next zone number
	a_zone_step: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |=> ##1
			(result_valid && (zone == zmt_pkg::ZONE_W'($past(zone, 2) + 6'd1))))
		else $error("result zones out of order");

	// overflow flag is the same on every result of a run
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |=> ##1 (row_overflow == $past(row_overflow, 2)))
		else $error("row overflow flag changed within a run");

endmodule

bind zone_mass_transfer_step zmt_port_check u_port_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.action       (action),
	.result_valid (result_valid),
	.zone         (zone),
	.last         (last),
	.row_overflow (row_overflow)
);

`default_nettype wire
